### rtl/nvs_pkg.sv
// Package for the nearest value search unit: widths, codes and chain token type.
package nvs_pkg;

   // Default set capacity and the number of cells in the search chain
   localparam int NVS_SET_DEPTH = 1024;
   localparam int NVS_CELLS     = 4;
   localparam int NVS_LANE_W    = $clog2(NVS_CELLS);

   // Field widths
   localparam int NVS_VALUE_W = 32;
   localparam int NVS_DIFF_W  = 32;
   localparam int NVS_SUM_W   = 33;
   localparam int NVS_INDEX_W = 10;

   // Request function codes
   localparam logic NVS_FUNC_APPEND = 1'b0;
   localparam logic NVS_FUNC_QUERY  = 1'b1;

   // Append write broadcast to the cells
   typedef struct packed {
      logic                   en;
      logic [NVS_LANE_W-1:0]  lane;
      logic [NVS_VALUE_W-1:0] data;
   } wr_type;

   // Search token that travels down the chain, one per row of the set
   typedef struct packed {
      logic                          valid;
      logic                          last;
      logic                          found;
      logic [NVS_DIFF_W-1:0]         diff;
      logic signed [NVS_VALUE_W-1:0] val;
   } token_type;

endpackage

### rtl/nvs_cell.sv
// One search cell: a bank of the set plus a compare stage that refines the passing token.
module nvs_cell #(
   parameter int ROWS    = 256,
   parameter int ROW_W   = 8,
   parameter int CNT_W   = 11,
   parameter int CELL_ID = 0,
   localparam int IDX_W  = ROW_W + nvs_pkg::NVS_LANE_W
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  nvs_pkg::wr_type                        wr,
   input  logic [ROW_W-1:0]                       wr_row,
   input  logic signed [nvs_pkg::NVS_VALUE_W-1:0] query,
   input  logic [CNT_W-1:0]                       count,
   input  nvs_pkg::token_type                     tok_in,
   input  logic [ROW_W-1:0]                       row_in,
   input  logic [IDX_W-1:0]                       idx_in,
   output nvs_pkg::token_type                     tok_out,
   output logic [ROW_W-1:0]                       row_out,
   output logic [IDX_W-1:0]                       idx_out
);

   localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
   localparam logic [nvs_pkg::NVS_LANE_W-1:0] LANE = nvs_pkg::NVS_LANE_W'(CELL_ID);

   logic [nvs_pkg::NVS_VALUE_W-1:0] bank [ROWS];
   logic [nvs_pkg::NVS_VALUE_W-1:0] rd_ff;

   nvs_pkg::token_type tok_s1_ff, tok_s1_in;
   logic [ROW_W-1:0]   row_s1_ff;
   logic [IDX_W-1:0]   idx_s1_ff;

   nvs_pkg::token_type tok_out_ff, tok_out_in;
   logic [ROW_W-1:0]   row_out_ff;
   logic [IDX_W-1:0]   idx_out_ff, idx_out_in;

   logic [IDX_W-1:0]                 entry_idx;
   logic                             eligible;
   logic [nvs_pkg::NVS_VALUE_W:0]    diff_pos;
   logic [nvs_pkg::NVS_DIFF_W-1:0]   abs_diff;
   logic                             take;

   // Store appends for this lane, read the row the token asks for
   always_ff @(posedge clock) begin
      if (wr.en && (wr.lane == LANE)) begin
         bank[wr_row] <= wr.data;
      end
      rd_ff <= bank[row_in];
   end

   // Hold the token beside the read data
   assign tok_s1_in = tok_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_s1_ff.valid  <= 1'b0;
         tok_out_ff.valid <= 1'b0;
      end else begin
         tok_s1_ff.valid  <= tok_s1_in.valid;
         tok_out_ff.valid <= tok_out_in.valid;
      end
      tok_s1_ff.last   <= tok_s1_in.last;
      tok_s1_ff.found  <= tok_s1_in.found;
      tok_s1_ff.diff   <= tok_s1_in.diff;
      tok_s1_ff.val    <= tok_s1_in.val;
      row_s1_ff        <= row_in;
      idx_s1_ff        <= idx_in;
      tok_out_ff.last  <= tok_out_in.last;
      tok_out_ff.found <= tok_out_in.found;
      tok_out_ff.diff  <= tok_out_in.diff;
      tok_out_ff.val   <= tok_out_in.val;
      row_out_ff       <= row_s1_ff;
      idx_out_ff       <= idx_out_in;
   end

   // Compare this entry against the best so far; strict less keeps the earliest on ties
   assign entry_idx = {row_s1_ff, LANE};
   assign eligible  = tok_s1_ff.valid && (CMP_W'(entry_idx) < CMP_W'(count));
   assign diff_pos  = {query[nvs_pkg::NVS_VALUE_W-1], query}
                    - {rd_ff[nvs_pkg::NVS_VALUE_W-1], rd_ff};
   assign abs_diff  = diff_pos[nvs_pkg::NVS_VALUE_W] ? nvs_pkg::NVS_DIFF_W'(-diff_pos)
                                                     : diff_pos[nvs_pkg::NVS_DIFF_W-1:0];
   assign take      = eligible && (!tok_s1_ff.found || (abs_diff < tok_s1_ff.diff));

   always_comb begin
      tok_out_in       = tok_s1_ff;
      idx_out_in       = idx_s1_ff;
      if (take) begin
         tok_out_in.found = 1'b1;
         tok_out_in.diff  = abs_diff;
         tok_out_in.val   = rd_ff;
         idx_out_in       = entry_idx;
      end
   end

   assign tok_out = tok_out_ff;
   assign row_out = row_out_ff;
   assign idx_out = idx_out_ff;

endmodule

### rtl/nearest_value_search_unit.sv
// An append is taken while idle; a query on stored values issues its rows into the cell
// chain and drains it before raising its response, while an empty-set query skips the chain.
// One row of four values enters the cell chain per cycle while issuing, and each of the
// four cells adds two stages; no new request is taken until a query's response is
// loaded, which waits while an earlier response stays stalled.
// Reset empties the set and clears control; stored values are not cleared.
module nearest_value_search_unit #(
   parameter int SET_DEPTH = nvs_pkg::NVS_SET_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_func,
   input  logic signed [nvs_pkg::NVS_VALUE_W-1:0] req_value,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [nvs_pkg::NVS_VALUE_W-1:0] rsp_nearest,
   output logic [nvs_pkg::NVS_INDEX_W-1:0]        rsp_nearest_index,
   output logic signed [nvs_pkg::NVS_SUM_W-1:0]   rsp_query_plus_nearest,
   output logic                                   rsp_empty_set
);

   localparam int LANE_W = nvs_pkg::NVS_LANE_W;
   localparam int CELLS  = nvs_pkg::NVS_CELLS;
   localparam int CNT_W  = $clog2(SET_DEPTH + 1);
   localparam int ROWS   = (SET_DEPTH + CELLS - 1) / CELLS;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W  = ROW_W + LANE_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [ROW_W-1:0] issue_row_ff, issue_row_in;
   logic [ROW_W-1:0] last_row;
   logic signed [nvs_pkg::NVS_VALUE_W-1:0] query_ff, query_in;

   logic                                   acc_found_ff, acc_found_in;
   logic [nvs_pkg::NVS_DIFF_W-1:0]         acc_diff_ff, acc_diff_in;
   logic signed [nvs_pkg::NVS_VALUE_W-1:0] acc_val_ff, acc_val_in;
   logic [IDX_W-1:0]                       acc_idx_ff, acc_idx_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [nvs_pkg::NVS_VALUE_W-1:0] rsp_nearest_ff, rsp_nearest_in;
   logic [nvs_pkg::NVS_INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic signed [nvs_pkg::NVS_SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic                                   rsp_empty_ff, rsp_empty_in;

   logic             accept;
   logic             out_free;
   logic [CNT_W-1:0] wr_addr;

   nvs_pkg::wr_type    wr;
   logic [ROW_W-1:0]   wr_row;
   nvs_pkg::token_type tok_chain [CELLS+1];
   logic [ROW_W-1:0]   row_chain [CELLS+1];
   logic [IDX_W-1:0]   idx_chain [CELLS+1];
   nvs_pkg::token_type tok_end;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_row  = ROW_W'((count_ff - CNT_W'(1)) >> LANE_W);

   // Append write: restart stores at position zero, a full set drops the value
   assign wr_addr  = req_restart ? '0 : count_ff;
   assign wr.en    = accept && (req_func == nvs_pkg::NVS_FUNC_APPEND)
                   && (req_restart || (count_ff < CNT_W'(SET_DEPTH)));
   assign wr.lane  = LANE_W'(wr_addr);
   assign wr.data  = req_value;
   assign wr_row   = ROW_W'(wr_addr >> LANE_W);

   // Inject one row token per cycle while issuing
   always_comb begin
      tok_chain[0]       = '0;
      tok_chain[0].valid = (state_ff == ST_ISSUE);
      tok_chain[0].last  = (issue_row_ff == last_row);
   end
   assign row_chain[0] = issue_row_ff;
   assign idx_chain[0] = '0;

   // Build the chain of cells
   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      nvs_cell #(
         .ROWS    (ROWS),
         .ROW_W   (ROW_W),
         .CNT_W   (CNT_W),
         .CELL_ID (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr      (wr),
         .wr_row  (wr_row),
         .query   (query_ff),
         .count   (count_ff),
         .tok_in  (tok_chain[k]),
         .row_in  (row_chain[k]),
         .idx_in  (idx_chain[k]),
         .tok_out (tok_chain[k+1]),
         .row_out (row_chain[k+1]),
         .idx_out (idx_chain[k+1])
      );
   end

   assign tok_end = tok_chain[CELLS];

   // Sequence requests, fold row results in order, and load the response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_row_in  = issue_row_ff;
      query_in      = query_ff;
      acc_found_in  = acc_found_ff;
      acc_diff_in   = acc_diff_ff;
      acc_val_in    = acc_val_ff;
      acc_idx_in    = acc_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_nearest_in = rsp_nearest_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (tok_end.valid && tok_end.found
          && (!acc_found_ff || (tok_end.diff < acc_diff_ff))) begin
         acc_found_in = 1'b1;
         acc_diff_in  = tok_end.diff;
         acc_val_in   = tok_end.val;
         acc_idx_in   = idx_chain[CELLS];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == nvs_pkg::NVS_FUNC_APPEND) begin
                  if (wr.en) begin
                     count_in = wr_addr + CNT_W'(1);
                  end
               end else begin
                  query_in     = req_value;
                  acc_found_in = 1'b0;
                  issue_row_in = '0;
                  state_in     = (count_ff == '0) ? ST_DONE : ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            issue_row_in = issue_row_ff + ROW_W'(1);
            if (issue_row_ff == last_row) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (tok_end.valid && tok_end.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_empty_in   = !acc_found_ff;
               rsp_nearest_in = acc_found_ff ? acc_val_ff : '0;
               rsp_index_in   = acc_found_ff ? nvs_pkg::NVS_INDEX_W'(acc_idx_ff) : '0;
               rsp_sum_in     = acc_found_ff
                              ? ({query_ff[nvs_pkg::NVS_VALUE_W-1], query_ff}
                                 + {acc_val_ff[nvs_pkg::NVS_VALUE_W-1], acc_val_ff})
                              : '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         acc_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         acc_found_ff <= acc_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_row_ff   <= issue_row_in;
      query_ff       <= query_in;
      acc_diff_ff    <= acc_diff_in;
      acc_val_ff     <= acc_val_in;
      acc_idx_ff     <= acc_idx_in;
      rsp_nearest_ff <= rsp_nearest_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_sum_ff     <= rsp_sum_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_nearest            = rsp_nearest_ff;
   assign rsp_nearest_index      = rsp_index_ff;
   assign rsp_query_plus_nearest = rsp_sum_ff;
   assign rsp_empty_set          = rsp_empty_ff;

endmodule

### rtl/nvs_checker.sv
// Port-level checks for the nearest value search unit, bound to the top level.
module nvs_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   req_func,
   input logic signed [nvs_pkg::NVS_VALUE_W-1:0] req_value,
   input logic                                   req_restart,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [nvs_pkg::NVS_VALUE_W-1:0] rsp_nearest,
   input logic [nvs_pkg::NVS_INDEX_W-1:0]        rsp_nearest_index,
   input logic signed [nvs_pkg::NVS_SUM_W-1:0]   rsp_query_plus_nearest,
   input logic                                   rsp_empty_set
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_nearest)
         && $stable(rsp_nearest_index) && $stable(rsp_query_plus_nearest)
         && $stable(rsp_empty_set))
      else $error("stalled response changed");

   // Zero the result fields on an empty set
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_set |-> (rsp_nearest == '0) && (rsp_nearest_index == '0)
         && (rsp_query_plus_nearest == '0))
      else $error("empty-set response carries nonzero fields");

   // Drop any response after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A response never rises in the cycle after a request is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("response raised right after a request");

   // Only a query can raise a response while requests flow
   a_append_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func == nvs_pkg::NVS_FUNC_APPEND)
         && !rsp_valid |=> !rsp_valid)
      else $error("append produced a response");

endmodule

bind nearest_value_search_unit nvs_checker u_nvs_checker (.*);
